// ===== hw/rtl/utf8_byte_decoder_top_defines.svh =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder assertion macros
// Concurrent assertion helpers; empty when building for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_DECODER_TOP_DEFINES_SVH
`define UTF8_BYTE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle
`define UTF8BD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("utf8bd assertion failed");

// Antecedent implies consequent in the next cycle
`define UTF8BD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("utf8bd assertion failed");

`else

`define UTF8BD_ASSERT_NOW(label, clk, rst, ante, cons)
`define UTF8BD_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hw/rtl/utf8bd_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder package
// Widths, state and class codes, byte classifier and transition table.
// ----------------------------------------------------------------------------
package utf8bd_pkg;

   localparam int BYTE_W   = 8;
   localparam int POINT_W  = 21;
   localparam int STATUS_W = 2;
   localparam int STATE_W  = 4;
   localparam int CLASS_W  = 4;
   localparam int CONT_W   = 6;

   // Automaton states; codes 9..15 are unused and act as reject
   typedef enum logic [STATE_W-1:0] {
      ST_ACCEPT  = 4'd0,
      ST_REJECT  = 4'd1,
      ST_NEED1   = 4'd2,
      ST_NEED2   = 4'd3,
      ST_AFTER_E0 = 4'd4,
      ST_AFTER_ED = 4'd5,
      ST_AFTER_F0 = 4'd6,
      ST_AFTER_F1 = 4'd7,
      ST_AFTER_F4 = 4'd8
   } state_type;

   // Byte classes
   typedef enum logic [CLASS_W-1:0] {
      CLS_ASCII    = 4'd0,
      CLS_CONT_LO  = 4'd1,
      CLS_LEAD2    = 4'd2,
      CLS_LEAD3    = 4'd3,
      CLS_ED       = 4'd4,
      CLS_F4       = 4'd5,
      CLS_LEAD4    = 4'd6,
      CLS_CONT_HI  = 4'd7,
      CLS_BAD      = 4'd8,
      CLS_CONT_MID = 4'd9,
      CLS_E0       = 4'd10,
      CLS_F0       = 4'd11
   } class_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_COMPLETE = 2'd0,
      STAT_PENDING  = 2'd1,
      STAT_REJECT   = 2'd2
   } status_type;

   // Result of one decode step
   typedef struct packed {
      state_type          state;
      status_type         status;
      logic [POINT_W-1:0] accum;
   } step_type;

   function automatic class_type byte_class(input logic [BYTE_W-1:0] b);
      class_type cls;
      if (b inside {[8'h00:8'h7F]})      cls = CLS_ASCII;
      else if (b inside {[8'h80:8'h8F]}) cls = CLS_CONT_LO;
      else if (b inside {[8'h90:8'h9F]}) cls = CLS_CONT_MID;
      else if (b inside {[8'hA0:8'hBF]}) cls = CLS_CONT_HI;
      else if (b inside {[8'hC0:8'hC1]}) cls = CLS_BAD;
      else if (b inside {[8'hC2:8'hDF]}) cls = CLS_LEAD2;
      else if (b == 8'hE0)               cls = CLS_E0;
      else if (b == 8'hED)               cls = CLS_ED;
      else if (b inside {[8'hE1:8'hEF]}) cls = CLS_LEAD3;
      else if (b == 8'hF0)               cls = CLS_F0;
      else if (b inside {[8'hF1:8'hF3]}) cls = CLS_LEAD4;
      else if (b == 8'hF4)               cls = CLS_F4;
      else                               cls = CLS_BAD;
      return cls;
   endfunction

   function automatic state_type next_state(input state_type st, input class_type cls);
      state_type nxt;
      nxt = ST_REJECT;
      case (st)
         ST_ACCEPT: begin
            case (cls)
               CLS_ASCII: nxt = ST_ACCEPT;
               CLS_LEAD2: nxt = ST_NEED1;
               CLS_LEAD3: nxt = ST_NEED2;
               CLS_ED:    nxt = ST_AFTER_ED;
               CLS_F4:    nxt = ST_AFTER_F4;
               CLS_LEAD4: nxt = ST_AFTER_F1;
               CLS_E0:    nxt = ST_AFTER_E0;
               CLS_F0:    nxt = ST_AFTER_F0;
               default:   nxt = ST_REJECT;
            endcase
         end
         ST_NEED1: begin
            if (cls inside {CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI}) nxt = ST_ACCEPT;
         end
         ST_NEED2: begin
            if (cls inside {CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI}) nxt = ST_NEED1;
         end
         ST_AFTER_E0: begin
            if (cls == CLS_CONT_HI) nxt = ST_NEED1;
         end
         ST_AFTER_ED: begin
            if (cls inside {CLS_CONT_LO, CLS_CONT_MID}) nxt = ST_NEED1;
         end
         ST_AFTER_F0: begin
            if (cls inside {CLS_CONT_MID, CLS_CONT_HI}) nxt = ST_NEED2;
         end
         ST_AFTER_F1: begin
            if (cls inside {CLS_CONT_LO, CLS_CONT_MID, CLS_CONT_HI}) nxt = ST_NEED2;
         end
         ST_AFTER_F4: begin
            if (cls == CLS_CONT_LO) nxt = ST_NEED2;
         end
         default: nxt = ST_REJECT;
      endcase
      return nxt;
   endfunction

endpackage

// ===== hw/rtl/utf8bd_if.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder channels
// Valid/ready request and response interfaces with source and sink views.
// ----------------------------------------------------------------------------
interface utf8bd_req_if;
   logic                         valid;
   logic                         ready;
   logic [utf8bd_pkg::BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface utf8bd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [utf8bd_pkg::STATUS_W-1:0] status;
   logic [utf8bd_pkg::POINT_W-1:0]  code_point;

   modport source (output valid, output status, output code_point, input ready);
   modport sink   (input valid, input status, input code_point, output ready);
endinterface

// ===== hw/rtl/utf8_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder top level
// Validating UTF-8 decoder, one byte per request, one response per byte.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one raw stream byte per request (in_byte). rsp_chan
//   returns, per byte, a status (0 complete, 1 pending, 2 rejected) and the
//   code point accumulated so far, valid as a scalar when status is complete.
//   Both channels are valid/ready; a request is taken when valid and ready
//   are high at a rising clock edge.
// Timing:
//   A request is registered, decoded combinationally and its response is
//   registered. Throughput is 1 byte per cycle while rsp_chan.ready is
//   high; the automaton state register updates as each byte moves to the
//   response register, so consecutive bytes follow back to back.
// Reset:
//   Synchronous reset empties both registers, puts the automaton in the
//   accept state and clears the accumulator. A rejected stream stays
//   rejected until reset.
// Stall:
//   When rsp_chan.ready is low the response holds; one more request can be
//   taken into the input register before req_chan.ready drops.
// ----------------------------------------------------------------------------
`include "utf8_byte_decoder_top_defines.svh"

module utf8_byte_decoder_top (
   input logic          clock,
   input logic          reset,
   utf8bd_req_if.sink   req_chan,
   utf8bd_rsp_if.source rsp_chan
);
   import utf8bd_pkg::*;

   logic               req_valid_ff, req_valid_in;
   logic [BYTE_W-1:0]  req_byte_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [POINT_W-1:0] rsp_point_ff;
   state_type          state_ff;
   logic [POINT_W-1:0] accum_ff;
   logic               advance;
   logic               req_take;
   step_type           step;

   // Move the staged byte forward when the response slot frees up
   assign advance            = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready     = !req_valid_ff || advance;
   assign req_take           = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.code_point = rsp_point_ff;

   utf8bd_step u_step (
      .in_byte (req_byte_ff),
      .state   (state_ff),
      .accum   (accum_ff),
      .step    (step)
   );

   // Next occupancy of both registers
   always_comb begin
      if (req_take) begin
         req_valid_in = 1'b1;
      end else if (advance) begin
         req_valid_in = 1'b0;
      end else begin
         req_valid_in = req_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= ST_ACCEPT;
         accum_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= step.state;
            accum_ff <= step.accum;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_byte_ff <= req_chan.in_byte;
      end
      if (advance) begin
         rsp_status_ff <= step.status;
         rsp_point_ff  <= step.accum;
      end
   end

   // Reject is absorbing
   `UTF8BD_ASSERT_NEXT(a_reject_sticky, clock, reset, state_ff == ST_REJECT, state_ff == ST_REJECT)
   // A rejected response implies the automaton sits in reject
   `UTF8BD_ASSERT_NOW(a_reject_state, clock, reset,
      rsp_valid_ff && rsp_status_ff == STAT_REJECT, state_ff == ST_REJECT)
   // A complete code point is a valid scalar value
   `UTF8BD_ASSERT_NOW(a_scalar_range, clock, reset,
      rsp_valid_ff && rsp_status_ff == STAT_COMPLETE,
      rsp_point_ff <= 21'h10FFFF && (rsp_point_ff < 21'h00D800 || rsp_point_ff > 21'h00DFFF))
   // A staged byte that cannot move stays staged
   `UTF8BD_ASSERT_NEXT(a_stage_hold, clock, reset, req_valid_ff && !advance, req_valid_ff)

endmodule

// ===== hw/rtl/utf8bd_step.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decode step
// Classifies one byte, steps the automaton and updates the accumulator.
// ----------------------------------------------------------------------------
module utf8bd_step (
   input  logic [utf8bd_pkg::BYTE_W-1:0]  in_byte,
   input  utf8bd_pkg::state_type          state,
   input  logic [utf8bd_pkg::POINT_W-1:0] accum,
   output utf8bd_pkg::step_type           step
);
   import utf8bd_pkg::*;

   class_type         cls;
   logic [BYTE_W-1:0] lead_mask;

   // Classify and mask a lead byte by its class
   assign cls       = byte_class(in_byte);
   assign lead_mask = 8'hFF >> cls;

   // Compute next state, accumulator and status
   always_comb begin
      if (state == ST_ACCEPT) begin
         step.accum = {{(POINT_W-BYTE_W){1'b0}}, lead_mask & in_byte};
      end else begin
         step.accum = {accum[POINT_W-CONT_W-1:0], in_byte[CONT_W-1:0]};
      end
      step.state = next_state(state, cls);
      case (step.state)
         ST_ACCEPT: step.status = STAT_COMPLETE;
         ST_REJECT: step.status = STAT_REJECT;
         default:   step.status = STAT_PENDING;
      endcase
   end

endmodule

// ===== tb/sv/utf8_byte_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder checker
// Watches the request and response channels and keeps its own copy of the
// decoder state. Each byte it sees accepted is decoded into an expected
// status and code point. Each response is compared in order against those.
// ----------------------------------------------------------------------------
module utf8_byte_decoder_checker (
   input  logic   clock,
   input  logic   reset,
   utf8bd_req_if  req_mon,
   utf8bd_rsp_if  rsp_mon,
   output int     mismatches,
   output int     in_flight
);
   import utf8bd_pkg::*;

   typedef struct {
      status_type         status;
      logic [POINT_W-1:0] point;
   } decoded_type;

   // Expected responses, oldest first
   decoded_type decoded_q [$];

   // Shadow copy of the automaton and the code point accumulator
   state_type          dec_state;
   logic [POINT_W-1:0] point_acc;

   initial begin
      mismatches = 0;
      in_flight  = 0;
      dec_state  = ST_ACCEPT;
      point_acc  = '0;
   end

   // Sort a byte into its class; the class also sets the lead byte mask
   function automatic class_type classify_byte(input logic [BYTE_W-1:0] b);
      if (b < 8'h80) return CLS_ASCII;
      if (b < 8'h90) return CLS_CONT_LO;
      if (b < 8'hA0) return CLS_CONT_MID;
      if (b < 8'hC0) return CLS_CONT_HI;
      if (b < 8'hC2) return CLS_BAD;
      if (b < 8'hE0) return CLS_LEAD2;
      if (b == 8'hE0) return CLS_E0;
      if (b == 8'hED) return CLS_ED;
      if (b < 8'hF0) return CLS_LEAD3;
      if (b == 8'hF0) return CLS_F0;
      if (b < 8'hF4) return CLS_LEAD4;
      if (b == 8'hF4) return CLS_F4;
      return CLS_BAD;
   endfunction

   // Next automaton state, decided from the byte value range each state allows
   function automatic state_type step_state(input state_type st, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
      state_type         ok_next;
      lo      = 8'h80;
      hi      = 8'hBF;
      ok_next = ST_REJECT;
      case (st)
         ST_ACCEPT: begin
            if (b < 8'h80) return ST_ACCEPT;
            if (b < 8'hC2) return ST_REJECT;
            if (b < 8'hE0) return ST_NEED1;
            if (b == 8'hE0) return ST_AFTER_E0;
            if (b == 8'hED) return ST_AFTER_ED;
            if (b < 8'hF0) return ST_NEED2;
            if (b == 8'hF0) return ST_AFTER_F0;
            if (b < 8'hF4) return ST_AFTER_F1;
            if (b == 8'hF4) return ST_AFTER_F4;
            return ST_REJECT;
         end
         ST_NEED1:    ok_next = ST_ACCEPT;
         ST_NEED2:    ok_next = ST_NEED1;
         ST_AFTER_E0: begin
            lo      = 8'hA0;
            ok_next = ST_NEED1;
         end
         ST_AFTER_ED: begin
            hi      = 8'h9F;
            ok_next = ST_NEED1;
         end
         ST_AFTER_F0: begin
            lo      = 8'h90;
            ok_next = ST_NEED2;
         end
         ST_AFTER_F1: ok_next = ST_NEED2;
         ST_AFTER_F4: begin
            hi      = 8'h8F;
            ok_next = ST_NEED2;
         end
         default:     return ST_REJECT;
      endcase
      return (b >= lo && b <= hi) ? ok_next : ST_REJECT;
   endfunction

   // Advance the shadow decoder by one byte and return what the block must answer
   function automatic decoded_type decode_byte(input logic [BYTE_W-1:0] b);
      class_type   cls;
      decoded_type res;
      cls = classify_byte(b);
      if (dec_state == ST_ACCEPT) begin
         point_acc      = '0;
         point_acc[7:0] = (8'hFF >> cls) & b;
      end else begin
         point_acc = {point_acc[POINT_W-CONT_W-1:0], b[CONT_W-1:0]};
      end
      dec_state  = step_state(dec_state, b);
      res.status = (dec_state == ST_ACCEPT) ? STAT_COMPLETE :
                   (dec_state == ST_REJECT) ? STAT_REJECT : STAT_PENDING;
      res.point  = point_acc;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Check responses before queuing new requests: a response never belongs
   // to a request taken at the same edge
   always @(posedge clock) begin : watch
      decoded_type want;
      if (reset) begin
         decoded_q.delete();
         dec_state = ST_ACCEPT;
         point_acc = '0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (decoded_q.size() == 0) begin
               report_mismatch($sformatf("response status %0d point %06h with no request open",
                                         rsp_mon.status, rsp_mon.code_point));
            end else begin
               want = decoded_q.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_mon.status, want.status));
               if (rsp_mon.code_point !== want.point)
                  report_mismatch($sformatf("code point %06h, expected %06h",
                                            rsp_mon.code_point, want.point));
            end
         end
         if (req_mon.valid && req_mon.ready)
            decoded_q.push_back(decode_byte(req_mon.in_byte));
      end
      in_flight <= decoded_q.size();
   end

endmodule

// ===== tb/sv/utf8_byte_decoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// UTF-8 byte decoder testbench
// Feeds boundary characters, then a long run of random well-formed UTF-8
// with random gaps and response stalls, then one broken sequence and noise
// to exercise the sticky reject state. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module utf8_byte_decoder_top_tb;
   import utf8bd_pkg::*;

   localparam int CLK_PERIOD   = 12;
   localparam int RESET_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 1000;
   localparam int NOISE_BYTES  = 80;
   localparam int DRAIN_CYCLES = 16;

   // Ways to break the stream once the valid run is over
   typedef enum int {
      BRK_OVERLONG2,
      BRK_OVERLONG3,
      BRK_OVERLONG4,
      BRK_SURROGATE,
      BRK_ABOVE_MAX,
      BRK_BAD_LEAD,
      BRK_STRAY_CONT,
      BRK_TRUNCATED
   } break_kind_type;

   logic clock;
   logic reset = 1'b1;
   int   mismatches;
   int   in_flight;
   int   cycle_count = 0;
   int   bytes_sent = 0;
   bit   quiet = 1'b0;

   utf8bd_req_if req_chan ();
   utf8bd_rsp_if rsp_chan ();

   utf8_byte_decoder_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   utf8_byte_decoder_checker decode_chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .mismatches (mismatches),
      .in_flight  (in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // Draw a random hold-off in cycles, none during a quiet spell
   function automatic int draw_wait();
      return quiet ? 0 : $urandom_range(0, 7);
   endfunction

   // Present one byte and hold it until the request is taken
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.in_byte = b;
      req_chan.valid   = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Encode a scalar value as UTF-8 and send its bytes
   task automatic send_char(input logic [POINT_W-1:0] cp);
      if (cp < 'h80) begin
         send_byte(cp[7:0]);
      end else if (cp < 'h800) begin
         send_byte({3'b110, cp[10:6]});
         send_byte({2'b10, cp[5:0]});
      end else if (cp < 'h10000) begin
         send_byte({4'b1110, cp[15:12]});
         send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end else begin
         send_byte({5'b11110, cp[20:18]});
         send_byte({2'b10, cp[17:12]});
         send_byte({2'b10, cp[11:6]});
         send_byte({2'b10, cp[5:0]});
      end
   endtask

   // Random scalar value: even spread over the four encoding lengths
   function automatic logic [POINT_W-1:0] draw_point();
      int unsigned cp;
      case ($urandom_range(0, 3))
         0: cp = $urandom_range(0, 'h7F);
         1: cp = $urandom_range('h80, 'h7FF);
         2: begin
            // skip the surrogate block
            cp = $urandom_range('h800, 'hF7FF);
            if (cp >= 'hD800) cp += 'h800;
         end
         default: cp = $urandom_range('h10000, 'h10FFFF);
      endcase
      return cp[POINT_W-1:0];
   endfunction

   // Drive a sequence that the decoder must reject
   task automatic send_broken(input break_kind_type kind);
      case (kind)
         BRK_OVERLONG2: begin
            send_byte(8'hC0 | 8'($urandom_range(0, 1)));
            send_byte(8'($urandom_range('h80, 'hBF)));
         end
         BRK_OVERLONG3: begin
            send_byte(8'hE0);
            send_byte(8'($urandom_range('h80, 'h9F)));
         end
         BRK_OVERLONG4: begin
            send_byte(8'hF0);
            send_byte(8'($urandom_range('h80, 'h8F)));
         end
         BRK_SURROGATE: begin
            send_byte(8'hED);
            send_byte(8'($urandom_range('hA0, 'hBF)));
         end
         BRK_ABOVE_MAX: begin
            send_byte(8'hF4);
            send_byte(8'($urandom_range('h90, 'hBF)));
         end
         BRK_BAD_LEAD:  send_byte(8'($urandom_range('hF5, 'hFF)));
         BRK_STRAY_CONT: send_byte(8'($urandom_range('h80, 'hBF)));
         default: begin
            send_byte(8'($urandom_range('hC2, 'hDF)));
            send_byte(8'($urandom_range(0, 'h7F)));
         end
      endcase
   endtask

   // Response side: stall a random number of cycles before each response
   initial begin : rsp_side
      int stall;
      rsp_chan.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
         @(negedge clock);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_byte_decoder_top verification failed");
         $finish;
      end
   end

   // Request side and verdict
   initial begin : req_side
      int unsigned boundary_points [9];
      int random_start;
      bit drained;
      boundary_points = '{
         'h0, 'h7F, 'h80, 'h7FF, 'h800, 'hD7FF, 'hFFFF, 'h10000, 'h10FFFF
      };
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      // Boundary characters of every encoding length
      foreach (boundary_points[i]) send_char(boundary_points[i][POINT_W-1:0]);

      // Random well-formed text; reject is sticky, so keep the stream valid
      random_start = bytes_sent;
      drained      = 1'b0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         if ((bytes_sent % 32) < 4) quiet = ($urandom_range(0, 3) == 0);
         send_char(draw_point());
         // once, let every outstanding response come back before going on
         if (!drained && bytes_sent - random_start >= RANDOM_BYTES / 2) begin
            drained        = 1'b1;
            req_chan.valid = 1'b0;
            do @(negedge clock); while (in_flight != 0);
         end
      end

      // Break the stream, then noise while the decoder sits in reject
      quiet = 1'b0;
      send_broken(break_kind_type'($urandom_range(0, 7)));
      send_byte(8'hFF);
      repeat (NOISE_BYTES) send_byte(8'($urandom_range(0, 255)));

      req_chan.valid = 1'b0;
      do @(negedge clock); while (in_flight != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0)
         $display("utf8_byte_decoder_top verification clean");
      else
         $display("utf8_byte_decoder_top verification failed");
      $finish;
   end

endmodule
